### rtl/triangle_unit_normal_defines.svh
// ----------------------------------------------------------------------------
// Triangle unit normal assertion macros
// Shared property forms for the checks at the end of the top module.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TUN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TUN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tun_pkg.sv
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Widths and stage counts shared by the interfaces and the datapath modules.
// ----------------------------------------------------------------------------
package tun_pkg;

	localparam int COORD_W = 24;
	localparam int EDGE_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * EDGE_W - 1;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W   = PROD_W;
	localparam int LO_W    = (MAG_W + 1) / 2;
	localparam int HI_W    = MAG_W - LO_W;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int SUM_W   = SQ_W + 2;
	localparam int ROOT_W  = SUM_W / 2;
	localparam int REM_W   = ROOT_W + 2;
	localparam int FRAC_W  = 30;
	localparam int QUO_W   = FRAC_W + 1;
	localparam int DREM_W  = ROOT_W + 1;
	localparam int NORM_W  = 32;
	localparam int FRONT_N = 6;
	localparam int PIPE_N  = FRONT_N + ROOT_W + QUO_W + 1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [EDGE_W-1:0]  edge_t;
	typedef logic        [MAG_W-1:0]   mag_t;
	typedef logic        [SQ_W-1:0]    sq_t;
	typedef logic signed [NORM_W-1:0]  norm_t;

	typedef struct packed {
		mag_t [2:0] mag;
		logic [2:0] neg;
		logic       deg;
	} side_t;

endpackage

### rtl/tun_if.sv
// ----------------------------------------------------------------------------
// Triangle unit normal channels
// Valid/ready channels for the triangle input items and normal result items.
// ----------------------------------------------------------------------------
interface tun_in_if
	import tun_pkg::*;
();
	logic   valid;
	logic   ready;
	coord_t ax, ay, az;
	coord_t bx, by, bz;
	coord_t cx, cy, cz;

	modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
	modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tun_out_if
	import tun_pkg::*;
();
	logic  valid;
	logic  ready;
	norm_t normal_x, normal_y, normal_z;
	logic  degenerate;

	modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
	modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

### rtl/tun_cross_lane.sv
// ----------------------------------------------------------------------------
// Cross product lane
// One component of the edge cross product and its exact square, four stages.
// ----------------------------------------------------------------------------
module tun_cross_lane
	import tun_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  edge_t uj,
	input  edge_t vm,
	input  edge_t um,
	input  edge_t vj,
	output mag_t  mag,
	output logic  neg,
	output sq_t   sq
);

	logic signed [2*EDGE_W-1:0] pf, qf;
	logic signed [PROD_W-1:0]   p_s2, q_s2;
	logic signed [CROSS_W-1:0]  cf, cabs;
	mag_t                       mag_s3, mag_s4, mag_s5;
	logic                       neg_s3, neg_s4, neg_s5;
	logic [2*HI_W-1:0]          hh_s4;
	logic [HI_W+LO_W-1:0]       hl_s4;
	logic [2*LO_W-1:0]          ll_s4;
	sq_t                        sq_s5;

	assign pf   = uj * vm;
	assign qf   = um * vj;
	assign cf   = {p_s2[PROD_W-1], p_s2} - {q_s2[PROD_W-1], q_s2};
	assign cabs = cf[CROSS_W-1] ? -cf : cf;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2   <= pf[PROD_W-1:0];
			q_s2   <= qf[PROD_W-1:0];
			neg_s3 <= cf[CROSS_W-1];
			mag_s3 <= cabs[MAG_W-1:0];
			// Square split into halves so each multiplier stays narrow.
			hh_s4  <= mag_s3[MAG_W-1:LO_W] * mag_s3[MAG_W-1:LO_W];
			hl_s4  <= mag_s3[MAG_W-1:LO_W] * mag_s3[LO_W-1:0];
			ll_s4  <= mag_s3[LO_W-1:0] * mag_s3[LO_W-1:0];
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
			sq_s5  <= (SQ_W'(hh_s4) << (2 * LO_W)) + (SQ_W'(hl_s4) << (LO_W + 1))
				+ SQ_W'(ll_s4);
			mag_s5 <= mag_s4;
			neg_s5 <= neg_s4;
		end
	end

	assign mag = mag_s5;
	assign neg = neg_s5;
	assign sq  = sq_s5;

endmodule

### rtl/tun_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one root bit per stage, restoring digit recurrence.
// ----------------------------------------------------------------------------
module tun_isqrt
	import tun_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [SUM_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);

	logic [REM_W-1:0]  rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0] root_s [ROOT_W+1];
	logic [SUM_W-1:0]  rad_s  [ROOT_W+1];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = rad;

	for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
		logic [REM_W-1:0] trial, tq;
		logic             ge;

		assign trial = {rem_s[j][REM_W-3:0], rad_s[j][SUM_W-1:SUM_W-2]};
		assign tq    = {root_s[j], 2'b01};
		assign ge    = trial >= tq;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? trial - tq : trial;
				root_s[j+1] <= {root_s[j][ROOT_W-2:0], ge};
				rad_s[j+1]  <= rad_s[j] << 2;
			end
		end
	end

	assign root = root_s[ROOT_W];

endmodule

### rtl/tun_div_lane.sv
// ----------------------------------------------------------------------------
// Normalizing divider lane
// Computes round(mag * 2^30 / den) with sign, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tun_div_lane
	import tun_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [ROOT_W-1:0] den,
	input  mag_t              mag,
	input  logic              neg,
	output norm_t             norm
);

	logic [DREM_W-1:0] rem_s [QUO_W+1];
	logic [ROOT_W-1:0] den_s [QUO_W+1];
	logic [QUO_W-1:0]  quo_s [QUO_W+1];
	logic              neg_s [QUO_W+1];
	logic              lsb_s1;
	logic [DREM_W:0]   twice;
	logic              up;
	norm_t             qm;
	norm_t             norm_s;

	// The shifted numerator's upper part is mag/2, below den for any nonzero cross product.
	assign rem_s[0] = DREM_W'(mag >> 1);
	assign den_s[0] = den;
	assign quo_s[0] = '0;
	assign neg_s[0] = neg;
	assign lsb_s1   = mag[0];

	for (genvar j = 0; j < QUO_W; j++) begin : g_stage
		logic [DREM_W-1:0] trial;
		logic              bit_in;
		logic              ge;

		// Only the first step brings in a numerator bit; the fraction bits are zero.
		if (j == 0) begin : g_first
			assign bit_in = lsb_s1;
		end else begin : g_rest
			assign bit_in = 1'b0;
		end

		assign trial = {rem_s[j][DREM_W-2:0], bit_in};
		assign ge    = trial >= {1'b0, den_s[j]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? trial - {1'b0, den_s[j]} : trial;
				den_s[j+1] <= den_s[j];
				quo_s[j+1] <= {quo_s[j][QUO_W-2:0], ge};
				neg_s[j+1] <= neg_s[j];
			end
		end
	end

	// Round half away from zero on the magnitude.
	assign twice = {rem_s[QUO_W], 1'b0};
	assign up    = twice >= {2'b00, den_s[QUO_W]};
	assign qm    = NORM_W'(quo_s[QUO_W]) + NORM_W'(up);

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s <= neg_s[QUO_W] ? -qm : qm;
		end
	end

	assign norm = norm_s;

endmodule

### rtl/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// Triangle unit normal
// Exact cross product of two triangle edges, normalized to signed Q1.30.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake      Payload
//  in_ch     in    valid/ready    ax ay az bx by bz cx cy cz (24-bit signed)
//  out_ch    out   valid/ready    normal_x normal_y normal_z (Q1.30), degenerate
//
//  One item per cycle enters unless the pipeline holds; the result passes the
//  edge, cross product and sum stages, the 50-stage square root, the dividers'
//  31 quotient stages and their rounding register, and the output register.
//  The whole pipeline advances together; it holds while a result sits in
//  the output register and is not taken, and in_ch.ready follows that.
//  Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`include "triangle_unit_normal_defines.svh"

module triangle_unit_normal
	import tun_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	tun_in_if.sink   in_ch,
	tun_out_if.source out_ch
);

	logic              en;
	logic [PIPE_N-1:0] vld_q;
	logic              out_vld_q;
	edge_t             u_s1 [3];
	edge_t             v_s1 [3];
	mag_t              mag_c [3];
	logic              neg_c [3];
	sq_t               sq_c [3];
	logic [SUM_W-1:0]  sum_s6;
	side_t             side_s [ROOT_W+1];
	logic              deg_s [QUO_W+2];
	logic [ROOT_W-1:0] root;
	norm_t             norm_l [3];
	norm_t             normal_x_q, normal_y_q, normal_z_q;
	logic              degenerate_q;

	assign en          = !out_vld_q || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[PIPE_N-2:0], in_ch.valid};
			out_vld_q <= vld_q[PIPE_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1[0] <= EDGE_W'(in_ch.bx) - EDGE_W'(in_ch.ax);
			u_s1[1] <= EDGE_W'(in_ch.by) - EDGE_W'(in_ch.ay);
			u_s1[2] <= EDGE_W'(in_ch.bz) - EDGE_W'(in_ch.az);
			v_s1[0] <= EDGE_W'(in_ch.cx) - EDGE_W'(in_ch.ax);
			v_s1[1] <= EDGE_W'(in_ch.cy) - EDGE_W'(in_ch.ay);
			v_s1[2] <= EDGE_W'(in_ch.cz) - EDGE_W'(in_ch.az);
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_cross
		tun_cross_lane u_lane (
			.clk (clk),
			.en  (en),
			.uj  (u_s1[(i + 1) % 3]),
			.vm  (v_s1[(i + 2) % 3]),
			.um  (u_s1[(i + 2) % 3]),
			.vj  (v_s1[(i + 1) % 3]),
			.mag (mag_c[i]),
			.neg (neg_c[i]),
			.sq  (sq_c[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s6 <= SUM_W'(sq_c[0]) + SUM_W'(sq_c[1]) + SUM_W'(sq_c[2]);
			for (int i = 0; i < 3; i++) begin
				side_s[0].mag[i] <= mag_c[i];
				side_s[0].neg[i] <= neg_c[i];
			end
			side_s[0].deg <= (mag_c[0] | mag_c[1] | mag_c[2]) == '0;
		end
	end

	tun_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sum_s6),
		.root (root)
	);

	// Component magnitudes ride alongside the square root.
	for (genvar k = 0; k < ROOT_W; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		tun_div_lane u_div (
			.clk  (clk),
			.en   (en),
			.den  (root),
			.mag  (side_s[ROOT_W].mag[i]),
			.neg  (side_s[ROOT_W].neg[i]),
			.norm (norm_l[i])
		);
	end

	assign deg_s[0] = side_s[ROOT_W].deg;

	for (genvar k = 0; k < QUO_W + 1; k++) begin : g_deg
		always_ff @(posedge clk) begin
			if (en) begin
				deg_s[k+1] <= deg_s[k];
			end
		end
	end

	// Merge: a zero cross product forces the components to zero.
	always_ff @(posedge clk) begin
		if (en) begin
			normal_x_q   <= deg_s[QUO_W+1] ? '0 : norm_l[0];
			normal_y_q   <= deg_s[QUO_W+1] ? '0 : norm_l[1];
			normal_z_q   <= deg_s[QUO_W+1] ? '0 : norm_l[2];
			degenerate_q <= deg_s[QUO_W+1];
		end
	end

	assign out_ch.valid      = out_vld_q;
	assign out_ch.normal_x   = normal_x_q;
	assign out_ch.normal_y   = normal_y_q;
	assign out_ch.normal_z   = normal_z_q;
	assign out_ch.degenerate = degenerate_q;

	`TUN_ASSERT_NOW(a_deg_zero, out_vld_q && degenerate_q,
		normal_x_q == '0 && normal_y_q == '0 && normal_z_q == '0,
		"degenerate result carries nonzero components")
	`TUN_ASSERT_NOW(a_unit_range, out_vld_q && !degenerate_q,
		normal_x_q <= (1 <<< FRAC_W) && normal_x_q >= -(1 <<< FRAC_W),
		"normal x component outside unit range")
	`TUN_ASSERT_NOW(a_root_align, vld_q[FRONT_N+ROOT_W-1],
		side_s[ROOT_W].deg == (root == '0),
		"square root and side data out of step")
	`TUN_ASSERT_NEXT(a_hold, !en, $stable(vld_q) && $stable(out_vld_q),
		"pipeline moved while stalled")

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle unit normal testbench
// Streams triangles through the normal pipeline under several idle and stall
// mixes and checks every result against a bit-exact normal predictor.
// ----------------------------------------------------------------------------
module tb;
	import tun_pkg::*;

	typedef struct packed {
		coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
	} triangle_t;

	typedef struct packed {
		norm_t nx, ny, nz;
		logic  deg;
	} normal_t;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	tun_in_if  in_ch ();
	tun_out_if out_ch ();

	triangle_unit_normal i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #5 clk = ~clk;

	triangle_t pending_tris[$];
	normal_t   expected_normals[$];
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        errors = 0;
	int        cycles = 0;

	// Exact cross product, integer length, and rounded Q1.30 components.
	function automatic normal_t unit_normal(triangle_t t);
		logic signed [24:0] u[3], v[3];
		logic signed [49:0] c[3];
		logic signed [127:0] cw;
		logic [127:0] mag[3], s, root, trial, num, q, r;
		logic [31:0] n[3];
		normal_t res;
		u[0] = $signed({t.bx[23], t.bx}) - $signed({t.ax[23], t.ax});
		u[1] = $signed({t.by[23], t.by}) - $signed({t.ay[23], t.ay});
		u[2] = $signed({t.bz[23], t.bz}) - $signed({t.az[23], t.az});
		v[0] = $signed({t.cx[23], t.cx}) - $signed({t.ax[23], t.ax});
		v[1] = $signed({t.cy[23], t.cy}) - $signed({t.ay[23], t.ay});
		v[2] = $signed({t.cz[23], t.cz}) - $signed({t.az[23], t.az});
		s = '0;
		for (int i = 0; i < 3; i++) begin
			c[i] = u[(i+1)%3] * v[(i+2)%3] - u[(i+2)%3] * v[(i+1)%3];
			cw = c[i];
			mag[i] = cw < 0 ? -cw : cw;
			s = s + mag[i] * mag[i];
		end
		if (s == 0) begin
			res = '{nx: '0, ny: '0, nz: '0, deg: 1'b1};
			return res;
		end
		root = '0;
		for (int k = 63; k >= 0; k--) begin
			trial = root | (128'd1 << k);
			if (trial * trial <= s)
				root = trial;
		end
		for (int i = 0; i < 3; i++) begin
			num = mag[i] << 30;
			q = num / root;
			r = num % root;
			if (2 * r >= root)
				q = q + 1;
			if (c[i] < 0)
				q = -q;
			n[i] = q[31:0];
		end
		res = '{nx: n[0], ny: n[1], nz: n[2], deg: 1'b0};
		return res;
	endfunction

	function automatic coord_t rand_coord(int spread);
		case (spread)
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(0, 64)) - 32);
			default: return coord_t'($signed($urandom_range(0, 8192)) - 4096);
		endcase
	endfunction

	function automatic triangle_t rand_triangle();
		triangle_t t;
		int spread;
		int kind;
		spread = $urandom_range(0, 2);
		kind = $urandom_range(0, 19);
		t = '{rand_coord(spread), rand_coord(spread), rand_coord(spread),
			rand_coord(spread), rand_coord(spread), rand_coord(spread),
			rand_coord(spread), rand_coord(spread), rand_coord(spread)};
		if (kind == 0) begin
			// Collapsed edge: B on top of A.
			t.bx = t.ax; t.by = t.ay; t.bz = t.az;
		end else if (kind == 1) begin
			// Collinear: C = A + 2(B - A), kept in range by small coordinates.
			t = '{rand_coord(1), rand_coord(1), rand_coord(1),
				rand_coord(1), rand_coord(1), rand_coord(1), '0, '0, '0};
			t.cx = coord_t'(2 * t.bx - t.ax);
			t.cy = coord_t'(2 * t.by - t.ay);
			t.cz = coord_t'(2 * t.bz - t.az);
		end else if (kind == 2) begin
			// Flat in z so one component dominates.
			t.az = t.bz; t.cz = t.bz;
		end
		return t;
	endfunction

	localparam coord_t CMAX = 24'sh7FFFFF;
	localparam coord_t CMIN = -24'sh800000;

	task automatic add_tri(triangle_t t);
		pending_tris = {pending_tris, t};
	endtask

	task automatic load_directed();
		triangle_t t;
		add_tri('0);
		add_tri('{1, 2, 3, 1, 2, 3, 1, 2, 3});
		add_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0});
		add_tri('{0, 0, 0, 0, 1, 0, 1, 0, 0});
		add_tri('{0, 0, 0, 0, 0, 1, 1, 0, 0});
		add_tri('{0, 0, 0, 1, 0, 0, 0, 0, 1});
		add_tri('{0, 0, 0, 1, 0, 0, 0, 1, 1});
		add_tri('{0, 0, 0, 1, 0, 0, 2, 3, 3});
		add_tri('{0, 0, 0, 1, 1, 1, 2, 2, 2});
		add_tri('{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN});
		add_tri('{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX});
		add_tri('{CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX});
		add_tri('{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN});
		add_tri('{CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX});
		add_tri('{CMIN, 0, 0, CMAX, 0, 0, 0, CMAX, CMAX});
		add_tri('{-1, -1, -1, 0, -1, -1, -1, 0, -1});
		add_tri('{0, 0, 0, 3, 0, 0, 0, 1, 1});
		add_tri('{0, 0, 0, 1, 2, 0, 0, 0, 7});
		add_tri('{5, -7, 9, 5, -7, 9, -3, 4, 100});
		add_tri('{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX});
		t = '{0, 0, 0, CMAX, 1, 0, 1, CMAX, 0};
		add_tri(t);
	endtask

	// Sender: present the next triangle unless idling this cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			{in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by, in_ch.bz,
				in_ch.cx, in_ch.cy, in_ch.cz} <= '0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (pending_tris.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				triangle_t t;
				t = pending_tris.pop_front();
				in_ch.valid <= 1'b1;
				{in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by, in_ch.bz,
					in_ch.cx, in_ch.cy, in_ch.cz} <= t;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver stall and result checking.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			normal_t got, want;
			out_ch.ready <= $urandom_range(0, 99) >= recv_stall_pct;
			if (in_ch.valid && in_ch.ready)
				expected_normals = {expected_normals, unit_normal({in_ch.ax, in_ch.ay,
					in_ch.az, in_ch.bx, in_ch.by, in_ch.bz, in_ch.cx, in_ch.cy,
					in_ch.cz})};
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.normal_x, out_ch.normal_y, out_ch.normal_z, out_ch.degenerate};
				if (expected_normals.size() == 0) begin
					$display("%0t: unexpected item %h", $time, got);
					errors++;
				end else begin
					want = expected_normals.pop_front();
					if (got.nx !== want.nx)
						$display("%0t: normal_x expected %0d got %0d", $time, want.nx, got.nx);
					if (got.ny !== want.ny)
						$display("%0t: normal_y expected %0d got %0d", $time, want.ny, got.ny);
					if (got.nz !== want.nz)
						$display("%0t: normal_z expected %0d got %0d", $time, want.nz, got.nz);
					if (got.deg !== want.deg)
						$display("%0t: degenerate expected %0b got %0b", $time,
							want.deg, got.deg);
					if (got !== want)
						errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int idle_mix[4][2];
		idle_mix = '{'{0, 0}, '{58, 0}, '{0, 58}, '{28, 28}};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		load_directed();
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_mix[ph][0];
			recv_stall_pct = idle_mix[ph][1];
			for (int i = 0; i < 375; i++)
				add_tri(rand_triangle());
			while (pending_tris.size() > 0 || in_ch.valid)
				@(posedge clk);
		end
		while (expected_normals.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && expected_normals.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

### sim.f
+incdir+rtl
rtl/tun_pkg.sv
rtl/tun_if.sv
rtl/tun_cross_lane.sv
rtl/tun_isqrt.sv
rtl/tun_div_lane.sv
rtl/triangle_unit_normal.sv
test/tb.sv
